// File: rtl/accel_window_rms_variance_peak_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer window statistics block
// Concurrent checks, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACCEL_WINDOW_RMS_VARIANCE_PEAK_TOP_DEFINES_SVH
`define ACCEL_WINDOW_RMS_VARIANCE_PEAK_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define AWRVP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("awrvp: invariant violated");
`define AWRVP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("awrvp: sequence check failed");
`else
`define AWRVP_ASSERT(lbl, prop)
`define AWRVP_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: rtl/awrvp_pkg.sv
// ----------------------------------------------------------------------------
// awrvp_pkg
// Shared widths, register indexes and reset values of the window statistics
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package awrvp_pkg;

  localparam int AXIS_W     = 16;   // raw axis count
  localparam int MAG_W      = 16;   // magnitude in milli-g
  localparam int ENERGY_W   = 32;   // x^2 + y^2 + z^2
  localparam int OUT_W      = 16;   // each result field
  localparam int WIN_W      = 11;   // window_len register
  localparam int SCALE_W    = 10;   // scale_ug_per_lsb register
  localparam int CFG_DATA_W = 11;
  localparam int DIVK_W     = 10;   // width of the micro-to-milli divisor

  localparam int MAX_WINDOW_DEF = 1024;

  localparam logic [DIVK_W-1:0]  UG_PER_MG     = 10'd1000;
  localparam logic [WIN_W-1:0]   WIN_LEN_RST   = 11'd520;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 10'd244;
  localparam logic [OUT_W-1:0]   OUT_SAT       = 16'hFFFF;

  // configuration register indexes
  localparam logic REG_WINDOW_LEN = 1'b0;
  localparam logic REG_SCALE      = 1'b1;

endpackage

`default_nettype wire

// File: rtl/awrvp_mul.sv
// ----------------------------------------------------------------------------
// awrvp_mul
// Shift-add multiplier, one multiplier bit per cycle, LSB first. Stops as
// soon as no set bit of the multiplier is left.
// ----------------------------------------------------------------------------
`default_nettype none

module awrvp_mul #(
  parameter int PW = 54,
  parameter int BW = 27
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [PW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic      [PW-1:0] prod,
  output logic               done
);

  logic [PW-1:0] a_r, a_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [PW-1:0] p_r, p_nxt;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    p_nxt = p_r;
    if (start) begin
      a_nxt = a;
      b_nxt = b;
      p_nxt = '0;
    end else if (b_r != '0) begin
      if (b_r[0]) begin
        p_nxt = p_r + a_r;
      end
      a_nxt = {a_r[PW-2:0], 1'b0};
      b_nxt = {1'b0, b_r[BW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
    end else begin
      b_r <= b_nxt;
    end
    a_r <= a_nxt;
    p_r <= p_nxt;
  end

  assign prod = p_r;
  assign done = (b_r == '0);

endmodule

`default_nettype wire

// File: rtl/awrvp_div.sv
// ----------------------------------------------------------------------------
// awrvp_div
// Restoring divider, one quotient bit per cycle. The dividend comes in
// left-aligned and steps gives the number of its significant bits; the
// quotient then sits in the low steps bits.
// ----------------------------------------------------------------------------
`default_nettype none

module awrvp_div #(
  parameter int DN_W   = 54,
  parameter int DD_W   = 22,
  parameter int STEP_W = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DN_W-1:0]   dividend,
  input  wire logic [DD_W-1:0]   divisor,
  input  wire logic [STEP_W-1:0] steps,
  output logic      [DN_W-1:0]   quotient,
  output logic                   done
);

  logic [DN_W-1:0]   q_r, q_nxt;
  logic [DD_W-1:0]   rem_r, rem_nxt;
  logic [DD_W-1:0]   d_r, d_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DD_W:0]     rem_sh;
  logic [DD_W:0]     diff;
  logic              ge;

  assign rem_sh = {rem_r, q_r[DN_W-1]};
  assign diff   = rem_sh - {1'b0, d_r};
  assign ge     = (rem_sh >= {1'b0, d_r});

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    d_nxt   = d_r;
    cnt_nxt = cnt_r;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      d_nxt   = divisor;
      cnt_nxt = steps;
    end else if (cnt_r != '0) begin
      rem_nxt = ge ? diff[DD_W-1:0] : rem_sh[DD_W-1:0];
      q_nxt   = {q_r[DN_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign quotient = q_r;
  assign done     = (cnt_r == '0);

endmodule

`default_nettype wire

// File: rtl/accel_window_rms_variance_peak_top.sv
// ----------------------------------------------------------------------------
// accel_window_rms_variance_peak_top
// Windowed RMS, variance and peak of accelerometer magnitude in milli-g.
// ----------------------------------------------------------------------------
// Each sample word needs three squares, a 16-step square root, the scale
// multiply, a 26-step divide by 1000 and the square of the magnitude, all run
// one bit per cycle on a shared shift-add multiplier, a shared restoring
// divider and a two-bits-per-step root unit; multiplies finish early when the
// multiplier runs out of set bits. The word that closes a window adds the
// mean-square divide, its root, three multiplies and the variance divide.
// in_tready is high only between samples; a finished result waits in the
// output register while the next window fills.
`default_nettype none

`include "accel_window_rms_variance_peak_top_defines.svh"

module accel_window_rms_variance_peak_top
  import awrvp_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [3*AXIS_W-1:0]   in_tdata,
  // out_tdata: rms_mg [15:0], variance_mg_sq [31:16], peak_mg [47:32]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [3*OUT_W-1:0]    out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W     = MAG_W + CNT_W;
  localparam int SQ_W      = ENERGY_W + CNT_W;
  localparam int PW        = 2 * SUM_W;
  localparam int NN_W      = 2 * CNT_W;
  localparam int DD_W      = (NN_W > DIVK_W) ? NN_W : DIVK_W;
  localparam int STEP_W    = $clog2(PW + 1);
  localparam int LIM_W     = (WIN_W > CNT_W) ? WIN_W : CNT_W;
  localparam int KP_W      = MAG_W + SCALE_W;
  localparam int RT_STEPS  = ENERGY_W / 2;
  localparam int RT_CNT_W  = $clog2(RT_STEPS + 1);
  localparam int RT_REM_W  = RT_STEPS + 2;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SQ_GO = 5'd1;
  localparam logic [4:0] ST_SQ_WT = 5'd2;
  localparam logic [4:0] ST_RT_GO = 5'd3;
  localparam logic [4:0] ST_RT_WT = 5'd4;
  localparam logic [4:0] ST_SC_GO = 5'd5;
  localparam logic [4:0] ST_SC_WT = 5'd6;
  localparam logic [4:0] ST_K_GO  = 5'd7;
  localparam logic [4:0] ST_K_WT  = 5'd8;
  localparam logic [4:0] ST_MM_GO = 5'd9;
  localparam logic [4:0] ST_MM_WT = 5'd10;
  localparam logic [4:0] ST_MS_GO = 5'd11;
  localparam logic [4:0] ST_MS_WT = 5'd12;
  localparam logic [4:0] ST_NQ_GO = 5'd13;
  localparam logic [4:0] ST_NQ_WT = 5'd14;
  localparam logic [4:0] ST_SS_GO = 5'd15;
  localparam logic [4:0] ST_SS_WT = 5'd16;
  localparam logic [4:0] ST_NN_GO = 5'd17;
  localparam logic [4:0] ST_NN_WT = 5'd18;
  localparam logic [4:0] ST_V_GO  = 5'd19;
  localparam logic [4:0] ST_V_WT  = 5'd20;
  localparam logic [4:0] ST_OUT   = 5'd21;

  logic [4:0]          state_r, state_nxt;
  logic [WIN_W-1:0]    win_len_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [AXIS_W-1:0]   ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;
  logic [ENERGY_W-1:0] rt_src_r, rt_src_nxt;
  logic [RT_REM_W-1:0] rt_rem_r, rt_rem_nxt;
  logic [MAG_W-1:0]    rt_root_r, rt_root_nxt;
  logic [RT_CNT_W-1:0] rt_cnt_r, rt_cnt_nxt;
  logic [MAG_W-1:0]    m_r, m_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SQ_W-1:0]     sumsq_r, sumsq_nxt;
  logic [MAG_W-1:0]    peak_r, peak_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic                end_r, end_nxt;
  logic [OUT_W-1:0]    rms_r, rms_nxt;
  logic [PW-1:0]       spread_r, spread_nxt;
  logic [NN_W-1:0]     nn_r, nn_nxt;
  logic [OUT_W-1:0]    var_r, var_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [3*OUT_W-1:0]  out_data_r, out_data_nxt;

  logic                mul_start;
  logic [PW-1:0]       mul_a;
  logic [SUM_W-1:0]    mul_b;
  logic [PW-1:0]       mul_p;
  logic                mul_done;
  logic                div_start;
  logic [PW-1:0]       div_dvd;
  logic [DD_W-1:0]     div_dvs;
  logic [STEP_W-1:0]   div_steps;
  logic [PW-1:0]       div_quo;
  logic                div_done;

  logic [AXIS_W-1:0]   axis_sel;
  logic [AXIS_W-1:0]   abs_x, abs_y, abs_z;
  logic [RT_REM_W+1:0] rt_rem_sh;
  logic [RT_REM_W+1:0] rt_trial;
  logic                rt_ge;
  logic [RT_REM_W+1:0] rt_diff;
  logic [LIM_W-1:0]    win_ext;
  logic [LIM_W-1:0]    limit;
  logic [CNT_W-1:0]    cnt_inc;
  logic                in_acc;
  logic                out_free;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // two's complement magnitude; the most negative count maps to 0x8000
  assign abs_x = in_tdata[AXIS_W-1] ?
                 AXIS_W'(~in_tdata[AXIS_W-1:0] + 1'b1) : in_tdata[AXIS_W-1:0];
  assign abs_y = in_tdata[2*AXIS_W-1] ?
                 AXIS_W'(~in_tdata[2*AXIS_W-1:AXIS_W] + 1'b1) : in_tdata[2*AXIS_W-1:AXIS_W];
  assign abs_z = in_tdata[3*AXIS_W-1] ?
                 AXIS_W'(~in_tdata[3*AXIS_W-1:2*AXIS_W] + 1'b1) :
                 in_tdata[3*AXIS_W-1:2*AXIS_W];

  always_comb begin
    case (op_r)
      2'd0:    axis_sel = ax_r;
      2'd1:    axis_sel = ay_r;
      default: axis_sel = az_r;
    endcase
  end

  // square root: bring down two bits, try root*4+1
  assign rt_rem_sh = {rt_rem_r, rt_src_r[ENERGY_W-1:ENERGY_W-2]};
  assign rt_trial  = {2'b00, rt_root_r, 2'b01};
  assign rt_ge     = (rt_rem_sh >= rt_trial);
  assign rt_diff   = rt_rem_sh - rt_trial;

  // zero counts as one, above MAX_WINDOW clamps
  assign win_ext = LIM_W'(win_len_r);
  always_comb begin
    if (win_ext == '0) begin
      limit = LIM_W'(1);
    end else if (win_ext > LIM_W'(MAX_WINDOW)) begin
      limit = LIM_W'(MAX_WINDOW);
    end else begin
      limit = win_ext;
    end
  end

  assign cnt_inc = cnt_r + 1'b1;

  // shared unit operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    div_steps = '0;
    case (state_r)
      ST_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = PW'(axis_sel);
        mul_b     = SUM_W'(axis_sel);
      end
      ST_SC_GO: begin
        mul_start = 1'b1;
        mul_a     = PW'(rt_root_r);
        mul_b     = SUM_W'(scale_r);
      end
      ST_MM_GO: begin
        mul_start = 1'b1;
        mul_a     = PW'(m_r);
        mul_b     = SUM_W'(m_r);
      end
      ST_NQ_GO: begin
        mul_start = 1'b1;
        mul_a     = PW'(sumsq_r);
        mul_b     = SUM_W'(n_r);
      end
      ST_SS_GO: begin
        mul_start = 1'b1;
        mul_a     = PW'(sum_r);
        mul_b     = sum_r;
      end
      ST_NN_GO: begin
        mul_start = 1'b1;
        mul_a     = PW'(n_r);
        mul_b     = SUM_W'(n_r);
      end
      ST_K_GO: begin
        div_start = 1'b1;
        div_dvd   = {mul_p[KP_W-1:0], {(PW-KP_W){1'b0}}};
        div_dvs   = DD_W'(UG_PER_MG);
        div_steps = STEP_W'(KP_W);
      end
      ST_MS_GO: begin
        div_start = 1'b1;
        div_dvd   = {sumsq_r, {(PW-SQ_W){1'b0}}};
        div_dvs   = DD_W'(n_r);
        div_steps = STEP_W'(SQ_W);
      end
      ST_V_GO: begin
        div_start = 1'b1;
        div_dvd   = spread_r;
        div_dvs   = DD_W'(nn_r);
        div_steps = STEP_W'(PW);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    az_nxt        = az_r;
    op_nxt        = op_r;
    energy_nxt    = energy_r;
    rt_src_nxt    = rt_src_r;
    rt_rem_nxt    = rt_rem_r;
    rt_root_nxt   = rt_root_r;
    rt_cnt_nxt    = rt_cnt_r;
    m_nxt         = m_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    peak_nxt      = peak_r;
    n_nxt         = n_r;
    end_nxt       = end_r;
    rms_nxt       = rms_r;
    spread_nxt    = spread_r;
    nn_nxt        = nn_r;
    var_nxt       = var_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ax_nxt     = abs_x;
          ay_nxt     = abs_y;
          az_nxt     = abs_z;
          op_nxt     = '0;
          energy_nxt = '0;
          state_nxt  = ST_SQ_GO;
        end
      end
      ST_SQ_GO: state_nxt = ST_SQ_WT;
      ST_SQ_WT: begin
        if (mul_done) begin
          energy_nxt = energy_r + mul_p[ENERGY_W-1:0];
          if (op_r == AXIS_LAST) begin
            state_nxt = ST_RT_GO;
          end else begin
            op_nxt    = op_r + 1'b1;
            state_nxt = ST_SQ_GO;
          end
        end
      end
      ST_RT_GO: begin
        rt_src_nxt  = end_r ? div_quo[ENERGY_W-1:0] : energy_r;
        rt_rem_nxt  = '0;
        rt_root_nxt = '0;
        rt_cnt_nxt  = RT_CNT_W'(RT_STEPS);
        state_nxt   = ST_RT_WT;
      end
      ST_RT_WT: begin
        if (rt_cnt_r != '0) begin
          rt_rem_nxt  = rt_ge ? rt_diff[RT_REM_W-1:0] : rt_rem_sh[RT_REM_W-1:0];
          rt_root_nxt = {rt_root_r[MAG_W-2:0], rt_ge};
          rt_src_nxt  = {rt_src_r[ENERGY_W-3:0], 2'b00};
          rt_cnt_nxt  = rt_cnt_r - 1'b1;
        end else if (end_r) begin
          rms_nxt   = rt_root_r;
          state_nxt = ST_NQ_GO;
        end else begin
          state_nxt = ST_SC_GO;
        end
      end
      ST_SC_GO: state_nxt = ST_SC_WT;
      ST_SC_WT: begin
        if (mul_done) begin
          state_nxt = ST_K_GO;
        end
      end
      ST_K_GO:  state_nxt = ST_K_WT;
      ST_K_WT: begin
        if (div_done) begin
          m_nxt     = div_quo[MAG_W-1:0];
          state_nxt = ST_MM_GO;
        end
      end
      ST_MM_GO: state_nxt = ST_MM_WT;
      ST_MM_WT: begin
        if (mul_done) begin
          cnt_nxt   = cnt_inc;
          sum_nxt   = sum_r + SUM_W'(m_r);
          sumsq_nxt = sumsq_r + SQ_W'(mul_p[2*MAG_W-1:0]);
          if (m_r > peak_r) begin
            peak_nxt = m_r;
          end
          if (LIM_W'(cnt_inc) >= limit) begin
            n_nxt     = cnt_inc;
            end_nxt   = 1'b1;
            state_nxt = ST_MS_GO;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MS_GO: state_nxt = ST_MS_WT;
      ST_MS_WT: begin
        if (div_done) begin
          state_nxt = ST_RT_GO;
        end
      end
      ST_NQ_GO: state_nxt = ST_NQ_WT;
      ST_NQ_WT: begin
        if (mul_done) begin
          spread_nxt = mul_p;
          state_nxt  = ST_SS_GO;
        end
      end
      ST_SS_GO: state_nxt = ST_SS_WT;
      ST_SS_WT: begin
        if (mul_done) begin
          spread_nxt = spread_r - mul_p;
          state_nxt  = ST_NN_GO;
        end
      end
      ST_NN_GO: state_nxt = ST_NN_WT;
      ST_NN_WT: begin
        if (mul_done) begin
          nn_nxt    = mul_p[NN_W-1:0];
          state_nxt = ST_V_GO;
        end
      end
      ST_V_GO:  state_nxt = ST_V_WT;
      ST_V_WT: begin
        if (div_done) begin
          var_nxt   = (div_quo[PW-1:OUT_W] != '0) ? OUT_SAT : div_quo[OUT_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free, then clear the window
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {peak_r, var_r, rms_r};
          cnt_nxt       = '0;
          sum_nxt       = '0;
          sumsq_nxt     = '0;
          peak_nxt      = '0;
          end_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_len_r   <= WIN_LEN_RST;
      scale_r     <= SCALE_RST;
      cnt_r       <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      peak_r      <= '0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      peak_r      <= peak_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WINDOW_LEN: win_len_r <= cfg_data[WIN_W-1:0];
          REG_SCALE:      scale_r   <= cfg_data[SCALE_W-1:0];
        endcase
      end
    end
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    az_r       <= az_nxt;
    op_r       <= op_nxt;
    energy_r   <= energy_nxt;
    rt_src_r   <= rt_src_nxt;
    rt_rem_r   <= rt_rem_nxt;
    rt_root_r  <= rt_root_nxt;
    rt_cnt_r   <= rt_cnt_nxt;
    m_r        <= m_nxt;
    n_r        <= n_nxt;
    rms_r      <= rms_nxt;
    spread_r   <= spread_nxt;
    nn_r       <= nn_nxt;
    var_r      <= var_nxt;
    out_data_r <= out_data_nxt;
  end

  awrvp_mul #(
    .PW (PW),
    .BW (SUM_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_p),
    .done  (mul_done)
  );

  awrvp_div #(
    .DN_W   (PW),
    .DD_W   (DD_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .quotient (div_quo),
    .done     (div_done)
  );

  `AWRVP_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(MAX_WINDOW))
  `AWRVP_ASSERT(a_acc_empty, (cnt_r == '0) |-> (sum_r == '0 && sumsq_r == '0 && peak_r == '0))
  `AWRVP_ASSERT(a_peak_le_sum, SUM_W'(peak_r) <= sum_r)
  `AWRVP_ASSERT_NEXT(a_out_from_close, !out_valid_r && state_r != ST_OUT, !out_valid_r)

endmodule

`default_nettype wire
